// ===== hdl/mi3_pkg.sv =====
// ----------------------------------------------------------------------------
// mi3_pkg: shared types and constants for the 3x3 matrix inverse
// Field widths, cofactor/determinant widths and the queue entry layout.
// ----------------------------------------------------------------------------
package mi3_pkg;

  localparam int unsigned FieldW = 32;
  localparam int unsigned NumEnt = 9;
  // cofactor: difference of two 64-bit products
  localparam int unsigned CofW   = 65;
  // determinant: sum of three 32 x 65 products
  localparam int unsigned DetW   = 98;
  // magnitudes
  localparam int unsigned CofAbsW = CofW - 1;
  localparam int unsigned DetAbsW = DetW - 1;
  // quotient bits kept (one above the result width for saturation)
  localparam int unsigned QuoW   = FieldW + 1;

  localparam logic [QuoW-1:0] LimitPos = 33'h0_7FFF_FFFF;
  localparam logic [QuoW-1:0] LimitNeg = 33'h0_8000_0000;
  localparam logic [FieldW-1:0] SatPos = 32'h7FFF_FFFF;
  localparam logic [FieldW-1:0] SatNeg = 32'h8000_0000;

  typedef logic signed [FieldW-1:0] field_t;
  typedef logic signed [CofW-1:0]   cof_t;
  typedef logic signed [DetW-1:0]   det_t;

  typedef struct packed {
    cof_t [NumEnt-1:0] cof;
    det_t              det;
    logic              singular;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } qword_t;

endpackage

// ===== hdl/mi3_front.sv =====
// ----------------------------------------------------------------------------
// mi3_front: cofactor and determinant pipeline
// Six free-running stages: products, cofactors, determinant partial products,
// terms, two additions. Flags a zero determinant on the way out.
// ----------------------------------------------------------------------------
module mi3_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  mi3_pkg::field_t  m_i [9],
  output mi3_pkg::qword_t  word_o
);

  localparam int unsigned PW = 2 * mi3_pkg::FieldW;
  localparam int unsigned HW = mi3_pkg::CofW - mi3_pkg::FieldW;
  localparam int unsigned TW = mi3_pkg::FieldW + HW;

  logic [5:0] vld_q;

  logic signed [PW-1:0] p0_q [9];
  logic signed [PW-1:0] p1_q [9];
  mi3_pkg::field_t      abc1_q [3];
  mi3_pkg::field_t      abc2_q [3];
  mi3_pkg::cof_t        cof2_q [9];
  mi3_pkg::cof_t        cof3_q [9];
  mi3_pkg::cof_t        cof4_q [9];
  mi3_pkg::cof_t        cof5_q [9];
  mi3_pkg::cof_t        cof6_q [9];
  logic signed [TW-1:0] plo_q [3];
  logic signed [TW-1:0] phi_q [3];
  mi3_pkg::det_t        term_q [3];
  mi3_pkg::det_t        s01_q;
  mi3_pkg::det_t        t2_q;
  mi3_pkg::det_t        det_q;

  // operand pairs: cof[k] = x0[k]*y0[k] - x1[k]*y1[k]
  mi3_pkg::field_t x0 [9], y0 [9], x1 [9], y1 [9];

  always_comb begin
    x0[0] = m_i[4]; y0[0] = m_i[8]; x1[0] = m_i[5]; y1[0] = m_i[7];
    x0[1] = m_i[2]; y0[1] = m_i[7]; x1[1] = m_i[1]; y1[1] = m_i[8];
    x0[2] = m_i[1]; y0[2] = m_i[5]; x1[2] = m_i[2]; y1[2] = m_i[4];
    x0[3] = m_i[5]; y0[3] = m_i[6]; x1[3] = m_i[3]; y1[3] = m_i[8];
    x0[4] = m_i[0]; y0[4] = m_i[8]; x1[4] = m_i[2]; y1[4] = m_i[6];
    x0[5] = m_i[2]; y0[5] = m_i[3]; x1[5] = m_i[0]; y1[5] = m_i[5];
    x0[6] = m_i[3]; y0[6] = m_i[7]; x1[6] = m_i[4]; y1[6] = m_i[6];
    x0[7] = m_i[1]; y0[7] = m_i[6]; x1[7] = m_i[0]; y1[7] = m_i[7];
    x0[8] = m_i[0]; y0[8] = m_i[4]; x1[8] = m_i[1]; y1[8] = m_i[3];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  // determinant uses row 0 against cofactors 0, 3, 6
  localparam int unsigned DetCof [3] = '{0, 3, 6};

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 9; k++) begin
      p0_q[k]   <= x0[k] * y0[k];
      p1_q[k]   <= x1[k] * y1[k];
      cof2_q[k] <= mi3_pkg::cof_t'(p0_q[k]) - mi3_pkg::cof_t'(p1_q[k]);
      cof3_q[k] <= cof2_q[k];
      cof4_q[k] <= cof3_q[k];
      cof5_q[k] <= cof4_q[k];
      cof6_q[k] <= cof5_q[k];
    end
    for (int r = 0; r < 3; r++) begin
      abc1_q[r] <= m_i[r];
      abc2_q[r] <= abc1_q[r];
      // split the cofactor: unsigned low word, signed high part
      plo_q[r] <= abc2_q[r] *
                  $signed({1'b0, cof2_q[DetCof[r]][mi3_pkg::FieldW-1:0]});
      phi_q[r] <= abc2_q[r] *
                  $signed(cof2_q[DetCof[r]][mi3_pkg::CofW-1:mi3_pkg::FieldW]);
      term_q[r] <= (mi3_pkg::det_t'(phi_q[r]) <<< mi3_pkg::FieldW) +
                   mi3_pkg::det_t'(plo_q[r]);
    end
    s01_q <= term_q[0] + term_q[1];
    t2_q  <= term_q[2];
    det_q <= s01_q + t2_q;
  end

  always_comb begin
    word_o.valid          = vld_q[5];
    word_o.entry.det      = det_q;
    word_o.entry.singular = (det_q == '0);
    for (int k = 0; k < 9; k++) begin
      word_o.entry.cof[k] = cof6_q[k];
    end
  end

endmodule

// ===== hdl/mi3_queue.sv =====
// ----------------------------------------------------------------------------
// mi3_queue: decoupling queue between front and back
// Small register FIFO; head is read directly, pop advances it.
// ----------------------------------------------------------------------------
module mi3_queue #(
  parameter int unsigned Depth = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mi3_pkg::qword_t wr_i,
  input  logic            pop_i,
  output mi3_pkg::qword_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  mi3_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [CntW-1:0] cnt_q;
  logic            do_pop;

  assign do_pop = pop_i && (cnt_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_i.valid) begin
        wp_q <= (wp_q == PtrW'(Depth - 1)) ? '0 : wp_q + 1'b1;
      end
      if (do_pop) begin
        rp_q <= (rp_q == PtrW'(Depth - 1)) ? '0 : rp_q + 1'b1;
      end
      cnt_q <= cnt_q + CntW'(wr_i.valid) - CntW'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.valid) begin
      mem_q[wp_q] <= wr_i.entry;
    end
  end

  assign head_o.valid = (cnt_q != '0);
  assign head_o.entry = mem_q[rp_q];

endmodule

// ===== hdl/mi3_back.sv =====
// ----------------------------------------------------------------------------
// mi3_back: scaled division pipeline
// Takes magnitudes, checks overflow, runs 33 restoring-division stages per
// entry, then applies sign and saturation into the output register.
// ----------------------------------------------------------------------------
module mi3_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mi3_pkg::qword_t head_i,
  output logic            pop_o,
  output logic            valid_o,
  input  logic            stall_i,
  output mi3_pkg::field_t inv_o [9],
  output logic            singular_o
);

  localparam int unsigned Steps = mi3_pkg::QuoW;
  localparam int unsigned CW    = mi3_pkg::CofAbsW;
  localparam int unsigned DW    = mi3_pkg::DetAbsW;

  logic en;
  assign en    = !valid_o || !stall_i;
  assign pop_o = en;

  logic [Steps:0]            vld_q;
  logic                      sing_q [Steps+1];
  logic [DW-1:0]             det_q  [Steps+1];
  logic                      neg_q  [Steps+1][9];
  logic                      ovf_q  [Steps+1][9];
  logic [DW-1:0]             rem_q  [Steps+1][9];
  logic [Steps-1:0]          quo_q  [Steps+1][9];
  logic                      lsb_q  [9];

  // stage 0: magnitudes and overflow check
  mi3_pkg::cof_t     cof_n [9];
  mi3_pkg::det_t     det_n;
  logic [CW-1:0]     cabs [9];
  logic [DW-1:0]     dabs;

  always_comb begin
    det_n = -head_i.entry.det;
    dabs  = head_i.entry.det[mi3_pkg::DetW-1] ? det_n[DW-1:0] : head_i.entry.det[DW-1:0];
    for (int k = 0; k < 9; k++) begin
      cof_n[k] = -head_i.entry.cof[k];
      cabs[k]  = head_i.entry.cof[k][mi3_pkg::CofW-1] ? cof_n[k][CW-1:0]
                                                      : head_i.entry.cof[k][CW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Steps-1:0], head_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sing_q[0] <= head_i.entry.singular;
      det_q[0]  <= dabs;
      for (int k = 0; k < 9; k++) begin
        neg_q[0][k] <= head_i.entry.cof[k][mi3_pkg::CofW-1] ^
                       head_i.entry.det[mi3_pkg::DetW-1];
        // quotient needs more than 33 bits exactly when |cof| >= 2|det|
        ovf_q[0][k] <= {1'b0, DW'(cabs[k])} >= {dabs, 1'b0};
        rem_q[0][k] <= DW'(cabs[k] >> 1);
        lsb_q[k]    <= cabs[k][0];
        quo_q[0][k] <= '0;
      end
    end
  end

  // division stages: stage s produces quotient bit Steps - s
  for (genvar s = 1; s <= Steps; s++) begin : g_step
    for (genvar k = 0; k < 9; k++) begin : g_lane
      logic          nbit;
      logic [DW:0]   shifted;
      logic [DW+1:0] diff;
      assign nbit    = (s == 1) ? lsb_q[k] : 1'b0;
      assign shifted = {rem_q[s-1][k], nbit};
      assign diff    = {1'b0, shifted} - {2'b00, det_q[s-1]};
      always_ff @(posedge clk_i) begin
        if (en) begin
          neg_q[s][k] <= neg_q[s-1][k];
          ovf_q[s][k] <= ovf_q[s-1][k];
          if (!diff[DW+1]) begin
            rem_q[s][k] <= diff[DW-1:0];
          end else begin
            rem_q[s][k] <= shifted[DW-1:0];
          end
          quo_q[s][k] <= {quo_q[s-1][k][Steps-2:0], !diff[DW+1]};
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        sing_q[s] <= sing_q[s-1];
        det_q[s]  <= det_q[s-1];
      end
    end
  end

  // sign and saturation into the output register
  mi3_pkg::field_t res [9];

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      if (sing_q[Steps]) begin
        res[k] = '0;
      end else if (ovf_q[Steps][k] ||
                   quo_q[Steps][k] > (neg_q[Steps][k] ? mi3_pkg::LimitNeg
                                                      : mi3_pkg::LimitPos)) begin
        res[k] = neg_q[Steps][k] ? mi3_pkg::SatNeg : mi3_pkg::SatPos;
      end else if (neg_q[Steps][k]) begin
        res[k] = -quo_q[Steps][k][mi3_pkg::FieldW-1:0];
      end else begin
        res[k] = quo_q[Steps][k][mi3_pkg::FieldW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en) begin
      valid_o <= vld_q[Steps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      inv_o      <= res;
      singular_o <= sing_q[Steps];
    end
  end

endmodule

// ===== hdl/matrix_inverse_3x3.sv =====
// ----------------------------------------------------------------------------
// matrix_inverse_3x3: exact adjugate inverse of a 3x3 Q16.16 matrix
// Input word: nine signed Q16.16 entries in row-major order. Output word: the
// nine Q16.16 inverse entries, truncated toward zero and saturated, plus a
// singular flag (entries zero when the determinant is zero).
// Both channels use valid/stall; a word moves when valid is high and stall low.
// Throughput: one matrix per cycle while the output is not stalled.
// Path through an empty pipe, from the accepting edge to the output word:
// 6 front stages (products, cofactors, determinant; the first loads at the
// accepting edge), the queue register, 1 magnitude stage, 33 division stages
// (one quotient bit per stage, nine lanes), 1 output reg.
// The front runs freely and lands in a QueueDepth-entry queue; in_stall_o
// rises when every queue slot is claimed by words in the front or the queue.
// When the receiver stalls, the back pipe and output register hold; the front
// keeps accepting until the queue credit runs out.
// Reset clears all valid state and the queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3 #(
  parameter int unsigned QueueDepth = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  logic [31:0]  m00_i,
  input  logic [31:0]  m01_i,
  input  logic [31:0]  m02_i,
  input  logic [31:0]  m10_i,
  input  logic [31:0]  m11_i,
  input  logic [31:0]  m12_i,
  input  logic [31:0]  m20_i,
  input  logic [31:0]  m21_i,
  input  logic [31:0]  m22_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output logic [31:0]  inv00_o,
  output logic [31:0]  inv01_o,
  output logic [31:0]  inv02_o,
  output logic [31:0]  inv10_o,
  output logic [31:0]  inv11_o,
  output logic [31:0]  inv12_o,
  output logic [31:0]  inv20_o,
  output logic [31:0]  inv21_o,
  output logic [31:0]  inv22_o,
  output logic         singular_o
);

  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  mi3_pkg::field_t m [9];
  mi3_pkg::field_t inv [9];
  mi3_pkg::qword_t fwd, head;
  logic            accept, pop, popped;
  logic [CntW-1:0] credit_q;

  assign m[0] = m00_i; assign m[1] = m01_i; assign m[2] = m02_i;
  assign m[3] = m10_i; assign m[4] = m11_i; assign m[5] = m12_i;
  assign m[6] = m20_i; assign m[7] = m21_i; assign m[8] = m22_i;

  assign in_stall_o = (credit_q == CntW'(QueueDepth));
  assign accept     = in_valid_i && !in_stall_o;
  assign popped     = pop && head.valid;

  // count words in the front pipe plus the queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_q <= '0;
    end else begin
      credit_q <= credit_q + CntW'(accept) - CntW'(popped);
    end
  end

  mi3_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .m_i     (m),
    .word_o  (fwd)
  );

  mi3_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (fwd),
    .pop_i  (pop),
    .head_o (head)
  );

  mi3_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .pop_o      (pop),
    .valid_o    (out_valid_o),
    .stall_i    (out_stall_i),
    .inv_o      (inv),
    .singular_o (singular_o)
  );

  assign inv00_o = inv[0]; assign inv01_o = inv[1]; assign inv02_o = inv[2];
  assign inv10_o = inv[3]; assign inv11_o = inv[4]; assign inv12_o = inv[5];
  assign inv20_o = inv[6]; assign inv21_o = inv[7]; assign inv22_o = inv[8];

endmodule

// ===== hdl/mi3_checker.sv =====
// ----------------------------------------------------------------------------
// mi3_checker: port-level checks for matrix_inverse_3x3
// Output hold under stall, singular results, and reset behavior.
// ----------------------------------------------------------------------------
module mi3_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] inv00_o,
  input logic [31:0] inv11_o,
  input logic [31:0] inv22_o,
  input logic [31:0] inv01_o,
  input logic        singular_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(inv00_o) &&
      $stable(inv11_o) && $stable(singular_o))
    else $error("output word changed under stall");

  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && singular_o |-> inv00_o == '0 && inv11_o == '0 &&
      inv22_o == '0 && inv01_o == '0)
    else $error("singular result with nonzero entries");

  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !out_valid_o)
    else $error("output valid right after reset");

endmodule

bind matrix_inverse_3x3 mi3_checker u_mi3_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .inv00_o     (inv00_o),
  .inv11_o     (inv11_o),
  .inv22_o     (inv22_o),
  .inv01_o     (inv01_o),
  .singular_o  (singular_o)
);
